// ===== design/eba_pkg.sv =====
// Package for the eight-bit ALU: operation codes, status bit positions and
// the packed transaction types of both channels. No dependencies.

package eba_pkg;

    typedef enum logic [3:0] {
        MODE_ADC = 4'd0,
        MODE_SBC = 4'd1,
        MODE_AND = 4'd2,
        MODE_XOR = 4'd3,
        MODE_ORA = 4'd4,
        MODE_CMP = 4'd5,
        MODE_ASL = 4'd6,
        MODE_LSR = 4'd7,
        MODE_ROL = 4'd8,
        MODE_ROR = 4'd9,
        MODE_INC = 4'd10,
        MODE_DEC = 4'd11,
        MODE_BIT = 4'd12,
        MODE_SET = 4'd13,
        MODE_CLR = 4'd14
    } t_mode;

    // Status bit positions
    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] reg_value;
        logic [7:0] operand_value;
        logic [7:0] status_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result_value;
        logic [7:0] status_out;
        logic       write_back;
    } t_alu_out;

endpackage

// ===== design/eba_core.sv =====
// Combinational ALU datapath: one operation on one input transaction.
// Depends on eba_pkg.

module eba_core (
    input  eba_pkg::t_alu_in  i_item,
    output eba_pkg::t_alu_out o_item
);
    import eba_pkg::*;

    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] st;
    logic       cin;
    logic [7:0] add_m;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] res;
    logic [7:0] st_n;
    logic       wb;

    assign a   = i_item.reg_value;
    assign m   = i_item.operand_value;
    assign st  = i_item.status_in;
    assign cin = st[FLAG_C];

    // sbc is A + ~M + C
    assign add_m = (t_mode'(i_item.mode) == MODE_SBC) ? ~m : m;
    assign sum   = {1'b0, a} + {1'b0, add_m} + {8'd0, cin};
    assign diff  = {1'b0, a} - {1'b0, m};

    always_comb begin
        res  = 8'd0;
        st_n = st;
        wb   = 1'b1;
        unique case (t_mode'(i_item.mode))
            MODE_ADC, MODE_SBC: begin
                res          = sum[7:0];
                st_n[FLAG_C] = sum[8];
                st_n[FLAG_V] = (sum[7] ^ a[7]) & (sum[7] ^ add_m[7]);
            end
            MODE_AND: res = a & m;
            MODE_XOR: res = a ^ m;
            MODE_ORA: res = a | m;
            MODE_CMP: begin
                st_n[FLAG_C] = ~diff[8];
                st_n[FLAG_Z] = (a == m);
                st_n[FLAG_N] = diff[7];
                wb           = 1'b0;
            end
            MODE_ASL: begin
                res          = {m[6:0], 1'b0};
                st_n[FLAG_C] = m[7];
            end
            MODE_ROL: begin
                res          = {m[6:0], cin};
                st_n[FLAG_C] = m[7];
            end
            MODE_LSR: begin
                res          = {1'b0, m[7:1]};
                st_n[FLAG_C] = m[0];
            end
            MODE_ROR: begin
                res          = {cin, m[7:1]};
                st_n[FLAG_C] = m[0];
            end
            MODE_INC: res = m + 8'd1;
            MODE_DEC: res = m - 8'd1;
            MODE_BIT: begin
                st_n[FLAG_N] = m[7];
                st_n[FLAG_V] = m[6];
                st_n[FLAG_Z] = ((a & m) == 8'd0);
                wb           = 1'b0;
            end
            MODE_SET: begin
                st_n = st | m;
                wb   = 1'b0;
            end
            MODE_CLR: begin
                st_n = st & ~m;
                wb   = 1'b0;
            end
            default: wb = 1'b0;   // reserved code: status passes through
        endcase
        if (wb) begin
            st_n[FLAG_N] = res[7];
            st_n[FLAG_Z] = (res == 8'd0);
        end
    end

    assign o_item.result_value = res;
    assign o_item.status_out   = st_n;
    assign o_item.write_back   = wb;

endmodule

// ===== design/eight_bit_alu_with_status_flags.sv =====
// Top level of the eight-bit ALU: input register, ALU datapath, result register.
// Depends on eba_pkg and eba_core.
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+---------------------------
//  input    | i_in_valid  | o_in_stall   | i_in_item  (t_alu_in)
//  result   | o_out_valid | i_out_stall  | o_out_item (t_alu_out)
//
// One transaction per cycle sustained while the result side is not stalled;
// the ALU sits between the input and result registers.
// Reset clears both valid bits; payload registers are not reset.
// A stalled result holds; the input register keeps taking transactions
// unless it is full and the result register is stalled.

module eight_bit_alu_with_status_flags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  eba_pkg::t_alu_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output eba_pkg::t_alu_out o_out_item
);
    import eba_pkg::*;

    logic     r_in_valid;
    t_alu_in  r_in_item;
    logic     r_out_valid;
    t_alu_out r_out_item;
    t_alu_out n_out_item;
    logic     out_hold;
    logic     in_hold;

    assign out_hold = r_out_valid & i_out_stall;
    assign in_hold  = r_in_valid & out_hold;

    eba_core u_core (
        .i_item (r_in_item),
        .o_item (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!in_hold) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!in_hold) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_hold) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_in_stall  = in_hold;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== design/eba_checker.sv =====
// Port-level checks for the eight-bit ALU, bound to the top level.
// Depends on eba_pkg and eight_bit_alu_with_status_flags.

module eba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input eba_pkg::t_alu_out o_out_item
);
    import eba_pkg::*;

    // input backpressure only ever comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // no write-back means the result byte is zero
    a_no_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.write_back) |-> (o_out_item.result_value == 8'd0))
        else $error("result byte nonzero without write-back");

    // written-back results carry matching N and Z
    a_wb_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.write_back) |->
        ((o_out_item.status_out[FLAG_N] == o_out_item.result_value[7]) &&
         (o_out_item.status_out[FLAG_Z] == (o_out_item.result_value == 8'd0))))
        else $error("N or Z does not match written-back result");

endmodule

bind eight_bit_alu_with_status_flags eba_checker u_eba_checker (.*);

// ===== dv/tb.sv =====
// Testbench for the eight-bit ALU. It sends operation transactions through the valid/stall
// channels and checks each result against an expected-value table or a predictor kept in this bench.
// Depends on eba_pkg and eight_bit_alu_with_status_flags.

module tb;
    import eba_pkg::*;

    localparam logic [3:0] MODE_RSVD       = 4'd15;
    localparam int         RAND_PER_PHASE  = 230;
    localparam int         HOLD_OFF_CYCLES = 64;

    typedef struct {
        t_alu_in  stim;
        bit       typed;
        t_alu_out want;
    } t_vec_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_alu_in   i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_alu_out  o_out_item;

    t_alu_out  expected_results[$];
    t_vec_row  dir_rows[$];
    int        err_count   = 0;
    int        tx_idle_pct = 14;
    int        rx_idle_pct = 52;
    int        hold_cycles = 0;

    eight_bit_alu_with_status_flags uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // 6502-style ALU: result byte, N/V/Z/C update, write-back flag
    function automatic t_alu_out alu_model(input t_alu_in x);
        t_alu_out   r;
        logic [8:0] sum;
        logic [7:0] a, m, st, res, addend, diff;
        logic       wb, cin;
        a      = x.reg_value;
        m      = x.operand_value;
        st     = x.status_in;
        res    = '0;
        wb     = 1'b1;
        cin    = st[FLAG_C];
        addend = m;
        case (x.mode)
            MODE_ADC, MODE_SBC: begin
                addend     = (x.mode == MODE_SBC) ? ~m : m;
                sum        = {1'b0, a} + {1'b0, addend} + {8'd0, cin};
                res        = sum[7:0];
                st[FLAG_C] = sum[8];
                st[FLAG_V] = (res[7] ^ a[7]) & (res[7] ^ addend[7]);
            end
            MODE_AND: res = a & m;
            MODE_XOR: res = a ^ m;
            MODE_ORA: res = a | m;
            MODE_CMP: begin
                diff       = a - m;
                st[FLAG_C] = (a >= m);
                st[FLAG_Z] = (a == m);
                st[FLAG_N] = diff[7];
                wb         = 1'b0;
            end
            MODE_ASL, MODE_ROL: begin
                res        = {m[6:0], (x.mode == MODE_ROL) ? cin : 1'b0};
                st[FLAG_C] = m[7];
            end
            MODE_LSR, MODE_ROR: begin
                res        = {(x.mode == MODE_ROR) ? cin : 1'b0, m[7:1]};
                st[FLAG_C] = m[0];
            end
            MODE_INC: res = m + 8'd1;
            MODE_DEC: res = m - 8'd1;
            MODE_BIT: begin
                st[FLAG_N] = m[7];
                st[FLAG_V] = m[6];
                st[FLAG_Z] = ((a & m) == 8'd0);
                wb         = 1'b0;
            end
            MODE_SET: begin
                st = st | m;
                wb = 1'b0;
            end
            MODE_CLR: begin
                st = st & ~m;
                wb = 1'b0;
            end
            default: wb = 1'b0;
        endcase
        if (wb) begin
            st[FLAG_N] = res[7];
            st[FLAG_Z] = (res == 8'd0);
        end else begin
            res = '0;
        end
        r.result_value = res;
        r.status_out   = st;
        r.write_back   = wb;
        return r;
    endfunction

    // corner bytes show up more often than a flat draw would give them
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(11))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void add_row(input logic [3:0] op, input logic [7:0] a, input logic [7:0] m,
                                    input logic [7:0] st, input bit typed, input logic [7:0] res,
                                    input logic [7:0] st_o, input logic wb);
        t_vec_row row;
        row.stim.mode          = op;
        row.stim.reg_value     = a;
        row.stim.operand_value = m;
        row.stim.status_in     = st;
        row.typed              = typed;
        row.want.result_value  = res;
        row.want.status_out    = st_o;
        row.want.write_back    = wb;
        dir_rows.push_back(row);
    endfunction

    task automatic offer(input t_alu_in stim, input bit typed, input t_alu_out want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= stim;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(typed ? want : alu_model(stim));
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Receiver: random stall, or a long hold-off when requested
    initial begin : result_stall
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_alu_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result transaction with none expected, actual %h",
                         $time, o_out_item);
                err_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("result_value", exp_r.result_value, o_out_item.result_value);
                check_field("status_out", exp_r.status_out, o_out_item.status_out);
                check_field("write_back", {7'd0, exp_r.write_back},
                            {7'd0, o_out_item.write_back});
            end
        end
    end

    initial begin : stimulus
        t_alu_in  stim;
        t_alu_out none;
        none = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //       op         A      M      P      typed  res    P out  wb
        add_row(MODE_ADC,  8'hFF, 8'h01, 8'h00, 1'b1, 8'h00, 8'h03, 1'b1);
        add_row(MODE_ADC,  8'h7F, 8'h00, 8'h01, 1'b1, 8'h80, 8'hC0, 1'b1);
        add_row(MODE_ADC,  8'h80, 8'h80, 8'h00, 1'b1, 8'h00, 8'h43, 1'b1);
        add_row(MODE_ADC,  8'h55, 8'hAA, 8'h3D, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(MODE_SBC,  8'h00, 8'h01, 8'h01, 1'b1, 8'hFF, 8'h80, 1'b1);
        add_row(MODE_SBC,  8'h80, 8'h01, 8'h01, 1'b1, 8'h7F, 8'h41, 1'b1);
        add_row(MODE_SBC,  8'h50, 8'h30, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(MODE_AND,  8'hF0, 8'h0F, 8'hFF, 1'b1, 8'h00, 8'h7F, 1'b1);
        add_row(MODE_XOR,  8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h80, 1'b1);
        add_row(MODE_ORA,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h02, 1'b1);
        add_row(MODE_CMP,  8'h10, 8'h10, 8'h00, 1'b1, 8'h00, 8'h03, 1'b0);
        add_row(MODE_CMP,  8'h00, 8'h01, 8'h00, 1'b1, 8'h00, 8'h80, 1'b0);
        add_row(MODE_CMP,  8'hFF, 8'h00, 8'h7C, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(MODE_ASL,  8'hAA, 8'h80, 8'h00, 1'b1, 8'h00, 8'h03, 1'b1);
        add_row(MODE_LSR,  8'h55, 8'h01, 8'h00, 1'b1, 8'h00, 8'h03, 1'b1);
        add_row(MODE_ROL,  8'h00, 8'h80, 8'h01, 1'b1, 8'h01, 8'h01, 1'b1);
        add_row(MODE_ROL,  8'h00, 8'h5A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(MODE_ROR,  8'h00, 8'h01, 8'h01, 1'b1, 8'h80, 8'h81, 1'b1);
        add_row(MODE_INC,  8'h00, 8'hFF, 8'h80, 1'b1, 8'h00, 8'h02, 1'b1);
        add_row(MODE_DEC,  8'h00, 8'h00, 8'h02, 1'b1, 8'hFF, 8'h80, 1'b1);
        add_row(MODE_DEC,  8'h00, 8'h80, 8'h41, 1'b0, 8'h00, 8'h00, 1'b0);
        add_row(MODE_BIT,  8'h00, 8'hC0, 8'h00, 1'b1, 8'h00, 8'hC2, 1'b0);
        add_row(MODE_BIT,  8'hFF, 8'h01, 8'hC2, 1'b1, 8'h00, 8'h00, 1'b0);
        add_row(MODE_SET,  8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'hFF, 1'b0);
        add_row(MODE_CLR,  8'h00, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b0);
        add_row(MODE_RSVD, 8'hA5, 8'h3C, 8'h5A, 1'b1, 8'h00, 8'h5A, 1'b0);

        foreach (dir_rows[i]) offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 14;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // sender keeps offering while the result side is held off
                    hold_cycles = HOLD_OFF_CYCLES;
                end
            endcase
            repeat (RAND_PER_PHASE) begin
                stim.mode          = 4'($urandom_range(15));
                stim.reg_value     = pick_byte();
                stim.operand_value = pick_byte();
                stim.status_in     = 8'($urandom_range(255));
                offer(stim, 1'b0, none);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("eight_bit_alu_with_status_flags verification clean");
        end else begin
            $display("eight_bit_alu_with_status_flags verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("eight_bit_alu_with_status_flags verification failed");
        $finish;
    end

endmodule

// ===== eight_bit_alu_with_status_flags.f =====
design/eba_pkg.sv
design/eba_core.sv
design/eight_bit_alu_with_status_flags.sv
design/eba_checker.sv
dv/tb.sv
